// ----- rtl/ac_phase_edge_catcher_assert.svh -----
// ----------------------------------------------------------------------------
// ac_phase_edge_catcher_assert
// Assertion macros used by the phase edge catcher checker.
// ----------------------------------------------------------------------------
`ifndef AC_PHASE_EDGE_CATCHER_ASSERT_SVH
`define AC_PHASE_EDGE_CATCHER_ASSERT_SVH

// Checked on every edge outside reset.
`define AC_PEC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define AC_PEC_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ac_pec_pkg.sv -----
// ----------------------------------------------------------------------------
// ac_pec_pkg
// Types, codes and helpers of the mains phase edge catcher.
// ----------------------------------------------------------------------------
package ac_pec_pkg;

  localparam int FILTER_TAPS = 5;
  localparam int COUNT_W     = $clog2(FILTER_TAPS + 1);
  localparam int CFG_IDX_W   = 3;

  localparam logic [7:0] SINCE_SAT = 8'd254;
  localparam logic [7:0] CNT_FULL  = 8'd255;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_EDGE_LEVEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_DELAY = 3'd4;

  localparam logic [1:0] STATUS_IDLE  = 2'd0;
  localparam logic [1:0] STATUS_CALIB = 2'd1;
  localparam logic [1:0] STATUS_READY = 2'd2;
  localparam logic [1:0] STATUS_ACERR = 2'd3;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_CALIB = 4'b0010,
    MODE_READY = 4'b0100,
    MODE_ACERR = 4'b1000
  } mode_t;

  typedef struct packed {
    logic                   operation;
    logic                   sample_bit;
    logic [FILTER_TAPS-1:0] start_samples;
  } req_t;

  typedef struct packed {
    logic       fire;
    logic [1:0] status;
    logic       filtered_level;
    logic [7:0] ticks_since_fire;
  } res_t;

  function automatic logic majority(input logic [FILTER_TAPS-1:0] h);
    logic [COUNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < FILTER_TAPS; i++) begin
      n = n + COUNT_W'(h[i]);
    end
    return (n > COUNT_W'(FILTER_TAPS / 2));
  endfunction

  function automatic logic [1:0] status_of(input mode_t m);
    logic [1:0] s;
    unique case (m)
      MODE_IDLE:  s = STATUS_IDLE;
      MODE_CALIB: s = STATUS_CALIB;
      MODE_READY: s = STATUS_READY;
      MODE_ACERR: s = STATUS_ACERR;
      default:    s = STATUS_IDLE;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/ac_phase_edge_catcher.sv -----
// Throughput: one request per cycle; the request register advances whenever
// the result register is empty or being taken.
// Reset: synchronous, clears both registers and loads the state and the
// configuration registers with their idle defaults.
// ----------------------------------------------------------------------------
// ac_phase_edge_catcher
// Mains zero-cross detector with a five-tap majority filter, edge period
// checking, AC error tracking and delayed phase pulse generation.
// ----------------------------------------------------------------------------
module ac_phase_edge_catcher (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  ac_pec_pkg::req_t                 req_data,
  output logic                             res_valid,
  input  logic                             res_ready,
  output ac_pec_pkg::res_t                 res_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ac_pec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                       cfg_data
);

  localparam int TAPS = ac_pec_pkg::FILTER_TAPS;

  logic       edge_level;
  logic [7:0] pulse_ticks;
  logic [7:0] min_period_ticks;
  logic [7:0] timeout_ticks;
  logic [7:0] offset_delay_ticks;

  logic             held_valid;
  ac_pec_pkg::req_t held;
  logic             advance;

  logic [TAPS-1:0]   history, history_next;
  logic              level, level_next;
  ac_pec_pkg::mode_t mode, mode_next;
  logic              in_stage, in_stage_next;
  logic [7:0]        run_ticks, run_ticks_next;
  logic [7:0]        since_fire, since_fire_next;
  logic [7:0]        error_count, error_count_next;
  logic [7:0]        ok_count, ok_count_next;
  logic [7:0]        delay_count, delay_count_next;
  logic              fire_next;
  logic [TAPS-1:0]   shifted;
  logic              lv;
  logic [7:0]        run_base;

  assign cfg_ready = 1'b1;
  assign advance   = held_valid && (!res_valid || res_ready);
  assign req_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_level         <= 1'b1;
      pulse_ticks        <= 8'd10;
      min_period_ticks   <= 8'd7;
      timeout_ticks      <= 8'd12;
      offset_delay_ticks <= 8'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ac_pec_pkg::REG_EDGE_LEVEL:   edge_level         <= cfg_data[0];
        ac_pec_pkg::REG_PULSE_TICKS:  pulse_ticks        <= cfg_data;
        ac_pec_pkg::REG_MIN_PERIOD:   min_period_ticks   <= cfg_data;
        ac_pec_pkg::REG_TIMEOUT:      timeout_ticks      <= cfg_data;
        ac_pec_pkg::REG_OFFSET_DELAY: offset_delay_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  assign shifted = {history[TAPS-2:0], held.sample_bit};
  assign lv      = ac_pec_pkg::majority(shifted);

  always_comb begin
    history_next     = history;
    level_next       = level;
    mode_next        = mode;
    in_stage_next    = in_stage;
    run_ticks_next   = run_ticks;
    since_fire_next  = since_fire;
    error_count_next = error_count;
    ok_count_next    = ok_count;
    delay_count_next = delay_count;
    fire_next        = 1'b0;
    run_base         = run_ticks;
    if (held.operation == ac_pec_pkg::OP_START) begin
      history_next     = held.start_samples;
      level_next       = ac_pec_pkg::majority(held.start_samples);
      mode_next        = ac_pec_pkg::MODE_CALIB;
      since_fire_next  = ac_pec_pkg::SINCE_SAT;
      error_count_next = ac_pec_pkg::CNT_FULL;
      ok_count_next    = ac_pec_pkg::CNT_FULL;
    end else begin
      if (delay_count != 8'd0) begin
        delay_count_next = delay_count - 8'd1;
        if (delay_count == 8'd1) begin
          fire_next       = 1'b1;
          since_fire_next = ac_pec_pkg::CNT_FULL;
        end
      end
      if (since_fire_next != ac_pec_pkg::SINCE_SAT) begin
        since_fire_next = since_fire_next + 8'd1;
      end
      if (mode != ac_pec_pkg::MODE_IDLE) begin
        history_next = shifted;
        if (lv == level) begin
          if (in_stage) begin
            // stage end
            if (run_ticks == pulse_ticks - 8'd1) begin
              run_base      = ac_pec_pkg::CNT_FULL;
              in_stage_next = 1'b0;
              if (mode == ac_pec_pkg::MODE_READY) begin
                if (offset_delay_ticks == 8'd0) begin
                  since_fire_next = 8'd0;
                  fire_next       = 1'b1;
                end else begin
                  delay_count_next = offset_delay_ticks;
                end
              end
            end
          end else if (run_ticks >= timeout_ticks) begin
            run_base         = ac_pec_pkg::CNT_FULL;
            ok_count_next    = ac_pec_pkg::CNT_FULL;
            error_count_next = error_count - 8'd1;
            if (error_count == 8'd1) begin
              mode_next = ac_pec_pkg::MODE_ACERR;
            end
          end
          run_ticks_next = run_base + 8'd1;
        end else begin
          level_next = lv;
          if (lv == edge_level) begin
            in_stage_next  = 1'b1;
            run_ticks_next = 8'd0;
            if (mode == ac_pec_pkg::MODE_CALIB) begin
              mode_next = ac_pec_pkg::MODE_READY;
            end else if (run_ticks > min_period_ticks) begin
              error_count_next = ac_pec_pkg::CNT_FULL;
              if (mode == ac_pec_pkg::MODE_READY) begin
                if (offset_delay_ticks == 8'd0) begin
                  since_fire_next = 8'd0;
                  fire_next       = 1'b1;
                end else begin
                  delay_count_next = offset_delay_ticks;
                end
              end
              ok_count_next = ok_count - 8'd1;
              if (ok_count == 8'd1) begin
                mode_next = ac_pec_pkg::MODE_READY;
              end
            end else begin
              ok_count_next    = ac_pec_pkg::CNT_FULL;
              error_count_next = error_count - 8'd1;
              if (error_count == 8'd1) begin
                mode_next = ac_pec_pkg::MODE_ACERR;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid  <= 1'b0;
      res_valid   <= 1'b0;
      history     <= '0;
      level       <= 1'b0;
      mode        <= ac_pec_pkg::MODE_IDLE;
      in_stage    <= 1'b0;
      run_ticks   <= 8'd0;
      since_fire  <= ac_pec_pkg::SINCE_SAT;
      error_count <= ac_pec_pkg::CNT_FULL;
      ok_count    <= ac_pec_pkg::CNT_FULL;
      delay_count <= 8'd0;
    end else begin
      if (req_ready) begin
        held_valid <= req_valid;
      end
      if (advance) begin
        res_valid   <= 1'b1;
        history     <= history_next;
        level       <= level_next;
        mode        <= mode_next;
        in_stage    <= in_stage_next;
        run_ticks   <= run_ticks_next;
        since_fire  <= since_fire_next;
        error_count <= error_count_next;
        ok_count    <= ok_count_next;
        delay_count <= delay_count_next;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      held <= req_data;
    end
    if (advance) begin
      res_data.fire             <= fire_next;
      res_data.status           <= ac_pec_pkg::status_of(mode_next);
      res_data.filtered_level   <= level_next;
      res_data.ticks_since_fire <= since_fire_next;
    end
  end

endmodule

// ----- rtl/ac_pec_checker.sv -----
// ----------------------------------------------------------------------------
// ac_pec_checker
// Port-level checks of the phase edge catcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "ac_phase_edge_catcher_assert.svh"

module ac_pec_checker (
  input logic             clk,
  input logic             rst,
  input logic             res_valid,
  input logic             res_ready,
  input ac_pec_pkg::res_t res_data
);

  `AC_PEC_ASSERT(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(res_data), "stalled result changed")
  `AC_PEC_ASSERT_RST(a_rst_empty, clk, rst |=> !res_valid, "result valid right after reset")
  `AC_PEC_ASSERT(a_fire_zero, clk, rst, res_valid && res_data.fire |-> res_data.ticks_since_fire == 8'd0, "pulse without cleared tick count")
  `AC_PEC_ASSERT(a_since_range, clk, rst, res_valid |-> res_data.ticks_since_fire != 8'd255, "tick count above saturation")
  `AC_PEC_ASSERT(a_idle_level, clk, rst, res_valid && res_data.status == ac_pec_pkg::STATUS_IDLE |-> !res_data.filtered_level, "level set while idle")

endmodule

bind ac_phase_edge_catcher ac_pec_checker u_checker (.*);

// ----- sim/ac_phase_edge_catcher_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ac_phase_edge_catcher_tb
// Drives sample ticks and start requests into the phase edge catcher and
// checks every result against a cycle-free model of the filter, edge period
// checks, AC error tracking and delayed pulse logic. A directed table comes
// first, then a timed coincidence of a pending and an immediate pulse, then
// random square waves, steady runs and noise under many register settings,
// then a trip into AC error on a steady level, good periods, a random segment.
// ----------------------------------------------------------------------------
module ac_phase_edge_catcher_tb;

  localparam int TAPS  = ac_pec_pkg::FILTER_TAPS;
  localparam int IDX_W = ac_pec_pkg::CFG_IDX_W;

  typedef struct packed {
    ac_pec_pkg::req_t req;
    logic             typed;
    ac_pec_pkg::res_t want;
  } dir_row_t;

  localparam int DIR_N = 20;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{'{ac_pec_pkg::OP_TICK,  1'b1, 5'b00000}, 1'b1,
      '{1'b0, ac_pec_pkg::STATUS_IDLE,  1'b0, ac_pec_pkg::SINCE_SAT}},
    '{'{ac_pec_pkg::OP_TICK,  1'b0, 5'b00000}, 1'b1,
      '{1'b0, ac_pec_pkg::STATUS_IDLE,  1'b0, ac_pec_pkg::SINCE_SAT}},
    '{'{ac_pec_pkg::OP_START, 1'b0, 5'b11111}, 1'b1,
      '{1'b0, ac_pec_pkg::STATUS_CALIB, 1'b1, ac_pec_pkg::SINCE_SAT}},
    '{'{ac_pec_pkg::OP_START, 1'b1, 5'b00000}, 1'b1,
      '{1'b0, ac_pec_pkg::STATUS_CALIB, 1'b0, ac_pec_pkg::SINCE_SAT}},
    '{'{ac_pec_pkg::OP_START, 1'b0, 5'b00111}, 1'b1,
      '{1'b0, ac_pec_pkg::STATUS_CALIB, 1'b1, ac_pec_pkg::SINCE_SAT}},
    '{'{ac_pec_pkg::OP_START, 1'b1, 5'b11000}, 1'b1,
      '{1'b0, ac_pec_pkg::STATUS_CALIB, 1'b0, ac_pec_pkg::SINCE_SAT}},
    '{'{ac_pec_pkg::OP_TICK,  1'b1, 5'b00000}, 1'b0, '0},
    '{'{ac_pec_pkg::OP_TICK,  1'b1, 5'b00000}, 1'b0, '0},
    '{'{ac_pec_pkg::OP_TICK,  1'b1, 5'b00000}, 1'b0, '0},
    '{'{ac_pec_pkg::OP_TICK,  1'b0, 5'b00000}, 1'b0, '0},
    '{'{ac_pec_pkg::OP_TICK,  1'b0, 5'b00000}, 1'b0, '0},
    '{'{ac_pec_pkg::OP_TICK,  1'b0, 5'b00000}, 1'b0, '0},
    '{'{ac_pec_pkg::OP_TICK,  1'b0, 5'b00000}, 1'b0, '0},
    '{'{ac_pec_pkg::OP_TICK,  1'b0, 5'b00000}, 1'b0, '0},
    '{'{ac_pec_pkg::OP_TICK,  1'b0, 5'b00000}, 1'b0, '0},
    '{'{ac_pec_pkg::OP_TICK,  1'b0, 5'b00000}, 1'b0, '0},
    '{'{ac_pec_pkg::OP_TICK,  1'b1, 5'b00000}, 1'b0, '0},
    '{'{ac_pec_pkg::OP_TICK,  1'b1, 5'b00000}, 1'b0, '0},
    '{'{ac_pec_pkg::OP_TICK,  1'b1, 5'b00000}, 1'b0, '0},
    '{'{ac_pec_pkg::OP_START, 1'b0, 5'b10101}, 1'b1,
      '{1'b0, ac_pec_pkg::STATUS_CALIB, 1'b1, ac_pec_pkg::SINCE_SAT}}
  };

  logic             clk;
  logic             rst        = 1'b1;
  logic             req_valid  = 1'b0;
  logic             req_ready;
  ac_pec_pkg::req_t req_data   = '0;
  logic             res_valid;
  logic             res_ready  = 1'b0;
  ac_pec_pkg::res_t res_data;
  logic             cfg_valid  = 1'b0;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index  = '0;
  logic [7:0]       cfg_data   = '0;

  logic             pend_typed = 1'b0;
  ac_pec_pkg::res_t pend_want  = '0;

  int snd_idle = 0;
  int rcv_idle = 0;

  ac_pec_pkg::res_t expected_q [$];
  ac_pec_pkg::res_t mon_want;
  ac_pec_pkg::res_t mon_pred;
  int   n_req   = 0;
  int   n_res   = 0;
  int   n_fire  = 0;
  int   n_acerr = 0;
  int   n_cfg   = 0;
  int   n_bad   = 0;

  // model registers and state
  logic            k_edge;
  logic [7:0]      k_pulse, k_minp, k_tmo, k_offs;
  logic [TAPS-1:0] f_hist;
  logic            f_lvl, f_stage;
  logic [1:0]      f_mode;
  logic [7:0]      f_run, f_since, f_err, f_ok, f_dly;

  ac_phase_edge_catcher u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400_000;
    $display("timeout: %0d results still pending", expected_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic tap_vote(input logic [TAPS-1:0] h);
    int ones;
    ones = 0;
    for (int i = 0; i < TAPS; i++) ones += h[i];
    return (2 * ones > TAPS);
  endfunction

  task automatic model_reset();
    k_edge  = 1'b1;
    k_pulse = 8'd10;
    k_minp  = 8'd7;
    k_tmo   = 8'd12;
    k_offs  = 8'd0;
    f_hist  = '0;
    f_lvl   = 1'b0;
    f_mode  = ac_pec_pkg::STATUS_IDLE;
    f_stage = 1'b0;
    f_run   = 8'd0;
    f_since = ac_pec_pkg::SINCE_SAT;
    f_err   = ac_pec_pkg::CNT_FULL;
    f_ok    = ac_pec_pkg::CNT_FULL;
    f_dly   = 8'd0;
  endtask

  task automatic arm_pulse(inout logic pulse);
    if (k_offs == 8'd0) begin
      f_since = 8'd0;
      pulse   = 1'b1;
    end else begin
      f_dly = k_offs;
    end
  endtask

  task automatic phase_step(input ac_pec_pkg::req_t r, output ac_pec_pkg::res_t y);
    logic       pulse, lv;
    logic [1:0] st;
    logic [7:0] t;
    pulse = 1'b0;
    if (r.operation == ac_pec_pkg::OP_START) begin
      f_hist  = r.start_samples;
      f_lvl   = tap_vote(f_hist);
      f_mode  = ac_pec_pkg::STATUS_CALIB;
      f_since = ac_pec_pkg::SINCE_SAT;
      f_err   = ac_pec_pkg::CNT_FULL;
      f_ok    = ac_pec_pkg::CNT_FULL;
    end else begin
      if (f_dly != 8'd0) begin
        f_dly = f_dly - 8'd1;
        if (f_dly == 8'd0) begin
          pulse   = 1'b1;
          f_since = ac_pec_pkg::CNT_FULL;
        end
      end
      if (f_since != ac_pec_pkg::SINCE_SAT) f_since = f_since + 8'd1;
      if (f_mode != ac_pec_pkg::STATUS_IDLE) begin
        f_hist = {f_hist[TAPS-2:0], r.sample_bit};
        lv     = tap_vote(f_hist);
        if (lv == f_lvl) begin
          t = f_run;
          if (f_stage) begin
            if (t == k_pulse - 8'd1) begin
              t       = ac_pec_pkg::CNT_FULL;
              f_stage = 1'b0;
              if (f_mode == ac_pec_pkg::STATUS_READY) arm_pulse(pulse);
            end
          end else if (t >= k_tmo) begin
            t     = ac_pec_pkg::CNT_FULL;
            f_ok  = ac_pec_pkg::CNT_FULL;
            f_err = f_err - 8'd1;
            if (f_err == 8'd0) f_mode = ac_pec_pkg::STATUS_ACERR;
          end
          f_run = t + 8'd1;
        end else begin
          f_lvl = lv;
          if (lv == k_edge) begin
            st      = f_mode;
            f_stage = 1'b1;
            if (st == ac_pec_pkg::STATUS_CALIB) begin
              st = ac_pec_pkg::STATUS_READY;
            end else if (f_run > k_minp) begin
              f_err = ac_pec_pkg::CNT_FULL;
              if (st == ac_pec_pkg::STATUS_READY) arm_pulse(pulse);
              f_ok = f_ok - 8'd1;
              if (f_ok == 8'd0) st = ac_pec_pkg::STATUS_READY;
            end else begin
              f_ok  = ac_pec_pkg::CNT_FULL;
              f_err = f_err - 8'd1;
              if (f_err == 8'd0) st = ac_pec_pkg::STATUS_ACERR;
            end
            f_mode = st;
            f_run  = 8'd0;
          end
        end
      end
    end
    y = '{pulse, f_mode, f_lvl, f_since};
  endtask

  always @(negedge clk) begin
    res_ready <= ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk) begin
    if (rst) begin
      model_reset();
    end else begin
      if (res_valid && res_ready) begin
        n_res++;
        if (res_data.fire) n_fire++;
        if (res_data.status == ac_pec_pkg::STATUS_ACERR) n_acerr++;
        if (expected_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("result %h arrived with nothing pending", res_data);
        end else begin
          mon_want = expected_q.pop_front();
          if (res_data !== mon_want) begin
            n_bad++;
            if (n_bad <= 10)
              $display("mismatch %0d exp/got fire %0b/%0b status %0d/%0d level %0b/%0b",
                       n_res, mon_want.fire, res_data.fire, mon_want.status,
                       res_data.status, mon_want.filtered_level,
                       res_data.filtered_level,
                       " since %0d/%0d",
                       mon_want.ticks_since_fire, res_data.ticks_since_fire);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        n_cfg++;
        case (cfg_index)
          ac_pec_pkg::REG_EDGE_LEVEL:   k_edge  = cfg_data[0];
          ac_pec_pkg::REG_PULSE_TICKS:  k_pulse = cfg_data;
          ac_pec_pkg::REG_MIN_PERIOD:   k_minp  = cfg_data;
          ac_pec_pkg::REG_TIMEOUT:      k_tmo   = cfg_data;
          ac_pec_pkg::REG_OFFSET_DELAY: k_offs  = cfg_data;
          default: ;
        endcase
      end
      if (req_valid && req_ready) begin
        n_req++;
        phase_step(req_data, mon_pred);
        expected_q.push_back(pend_typed ? pend_want : mon_pred);
      end
    end
  end

  task automatic send_req(input ac_pec_pkg::req_t r, input logic typed,
                          input ac_pec_pkg::res_t want);
    while ($urandom_range(99) < snd_idle) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid  <= 1'b1;
    req_data   <= r;
    pend_typed <= typed;
    pend_want  <= want;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  task automatic send_tick(input logic b);
    ac_pec_pkg::req_t r;
    r.operation     = ac_pec_pkg::OP_TICK;
    r.sample_bit    = b;
    r.start_samples = TAPS'($urandom_range(31));
    send_req(r, 1'b0, '0);
  endtask

  task automatic send_start(input logic [TAPS-1:0] s);
    ac_pec_pkg::req_t r;
    r.operation     = ac_pec_pkg::OP_START;
    r.sample_bit    = 1'($urandom_range(1));
    r.start_samples = s;
    send_req(r, 1'b0, '0);
  endtask

  task automatic send_bits(input logic [63:0] pat, input int n);
    for (int i = n - 1; i >= 0; i--) send_tick(pat[i]);
  endtask

  // square wave of the given half period, optionally flipped at random
  task automatic run_wave(input int n, input int half, input int noise_pct);
    logic ph, b;
    ph = 1'($urandom_range(1));
    for (int i = 0; i < n; i++) begin
      b = ph ^ 1'((i / half) % 2);
      if ($urandom_range(99) < noise_pct) b = ~b;
      send_tick(b);
    end
  endtask

  task automatic random_segment(input int budget);
    int first, pick;
    first = n_req;
    send_start(TAPS'($urandom_range(31)));
    while (n_req - first < budget) begin
      pick = $urandom_range(99);
      if (pick < 55)
        run_wave($urandom_range(10, 60), $urandom_range(2, 12),
                 ($urandom_range(1) == 1) ? 0 : 8);
      else if (pick < 80)
        run_wave(($urandom_range(9) == 0) ? $urandom_range(200, 300) : $urandom_range(5, 60),
                 1000, 0);
      else if (pick < 95)
        run_wave($urandom_range(3, 15), 1, 50);
      else
        send_start(TAPS'($urandom_range(31)));
    end
  endtask

  task automatic cfg_put(input logic [IDX_W-1:0] idx, input logic [7:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic load_cfg(input logic [7:0] e, p, m, t, o);
    cfg_put(ac_pec_pkg::REG_EDGE_LEVEL, e);
    cfg_put(ac_pec_pkg::REG_PULSE_TICKS, p);
    cfg_put(ac_pec_pkg::REG_MIN_PERIOD, m);
    cfg_put(ac_pec_pkg::REG_TIMEOUT, t);
    cfg_put(ac_pec_pkg::REG_OFFSET_DELAY, o);
    if ($urandom_range(3) == 0)
      cfg_put(ac_pec_pkg::REG_OFFSET_DELAY + IDX_W'($urandom_range(1, 3)),
              8'($urandom_range(255)));
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    logic [7:0] ac_edge, ac_offs;
    snd_idle = 6;
    rcv_idle = 65;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++)
      send_req(DIR_TAB[i].req, DIR_TAB[i].typed, DIR_TAB[i].want);

    // stage end leaves a 6-tick delay pending; the good edge 6 ticks later
    // fires at once with the delay cleared, so both land on one tick
    settle();
    load_cfg(8'd1, 8'd10, 8'd2, 8'd12, 8'd6);
    send_start(5'b00000);
    send_bits(64'h1FFF, 13);
    settle();
    load_cfg(8'd1, 8'd10, 8'd2, 8'd12, 8'd0);
    send_bits(64'b000111, 6);

    for (int s = 0; s < 8; s++) begin
      if (s == 4) begin
        snd_idle = 65;
        rcv_idle = 6;
      end
      settle();
      case (s)
        0: load_cfg(8'h01, 8'd1, 8'd0, 8'd1, 8'd0);
        1: load_cfg(8'hFE, 8'd255, 8'd255, 8'd255, 8'd255);
        2: load_cfg(8'($urandom_range(255)), 8'd0, 8'($urandom_range(15)), 8'd0,
                    8'($urandom_range(1, 20)));
        default:
          load_cfg(8'($urandom_range(255)),
                   ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(1, 20)),
                   8'($urandom_range(15)), 8'($urandom_range(1, 40)),
                   ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom_range(1, 25)));
      endcase
      random_segment(65);
    end

    // timeouts on a steady level into AC error, then good periods in AC error
    snd_idle = 0;
    rcv_idle = 0;
    ac_edge  = 8'($urandom_range(1));
    ac_offs  = 8'($urandom_range(5));
    settle();
    load_cfg(ac_edge, 8'd1, 8'd0, 8'd0, ac_offs);
    send_start(5'b00000);
    run_wave(20, 3, 0);
    run_wave(280, 1000, 0);
    settle();
    load_cfg(ac_edge, 8'd255, 8'd0, 8'd255, ac_offs);
    run_wave(60, 2, 0);
    random_segment(65);

    settle();
    repeat (8) @(negedge clk);
    $display("covered %0d requests, %0d results and %0d register writes",
             n_req, n_res, n_cfg);
    $display("saw %0d phase pulses and %0d results in AC error status", n_fire, n_acerr);
    if (n_bad == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures", n_bad);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
